/* hdl/icy_pkg.sv */
// ----------------------------------------------------------------------------
// icy_pkg
// Shared constants, types and the title key table for the ICY metadata demux.
// ----------------------------------------------------------------------------
package icy_pkg;

  localparam int META_DEPTH  = 512;
  localparam int TITLE_DEPTH = 256;
  localparam int MADDR_W     = $clog2(META_DEPTH);
  localparam int TADDR_W     = $clog2(TITLE_DEPTH);
  localparam int MPOS_W      = 12;
  localparam int IVL_W       = 24;
  localparam int KEY_LEN     = 13;
  localparam int BLOCK_SHIFT = 4;   // block length unit of 16 bytes

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_TITLE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_META  = 2'd1
  } phase_t;

  typedef enum logic [1:0] {
    T_IDLE = 2'd0,
    T_READ = 2'd1,
    T_SCAN = 2'd2
  } top_st_t;

  typedef enum logic [1:0] {
    SC_IDLE = 2'd0,
    SC_FIND = 2'd1,
    SC_COPY = 2'd2,
    SC_DONE = 2'd3
  } scan_st_t;

  typedef struct packed {
    logic              start;
    logic [MPOS_W-1:0] limit;
  } scan_ctl_t;

  typedef struct packed {
    logic done;
    logic updated;
  } scan_sts_t;

  // "StreamTitle='" one character at a time
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6D; // m
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h69; // i
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6C; // l
      4'd10:   c = 8'h65; // e
      4'd11:   c = 8'h3D; // =
      4'd12:   c = 8'h27; // '
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hdl/icy_metadata_demux.sv */
// ----------------------------------------------------------------------------
// icy_metadata_demux
// Splits an ICY stream into audio bytes and metadata blocks, extracts the
// stream title and serves title characters on request.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beat (in_valid/in_stall): in_action 0 carries one stream byte in
//    in_data_byte; in_action 1 reads title character in_title_index.
//  - Output beat (out_valid/out_stall): out_kind audio, block end or title
//    char, with out_out_byte, out_title_updated and out_title_length.
//  - cfg_wr_en/cfg_wr_data write meta_interval and restart the framing;
//    write only while the block is idle.
// Flow:
//  - Audio, length and non-final metadata bytes: taken back to back while
//    no result is stalled; an audio result shows in the cycle after acceptance.
//  - Title read: registered title store read, then the output register.
//  - Last metadata byte: the scanner walks the metadata store one byte per
//    cycle up to min(block length, 511) or the first zero byte, then copies
//    a found title one byte per cycle; the block end beat follows the
//    scanner's done state through the output register.
// Reset clears the framing, interval and title length; stores keep data.
// While a result is stalled the input is stalled too; the held beat does
// not change.
// ----------------------------------------------------------------------------
module icy_metadata_demux (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [icy_pkg::IVL_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [7:0]                  in_data_byte,
  input  logic [7:0]                  in_title_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_out_byte,
  output logic                        out_title_updated,
  output logic [7:0]                  out_title_length
);
  import icy_pkg::*;

  top_st_t            st_r, st_nxt;
  logic [IVL_W-1:0]   ivl_r, ivl_nxt;
  phase_t             ph_r, ph_nxt;
  logic [IVL_W-1:0]   acnt_r, acnt_nxt;
  logic [MPOS_W-1:0]  msize_r, msize_nxt;
  logic [MPOS_W-1:0]  mpos_r, mpos_nxt;
  logic               rd_hit_r, rd_hit_nxt;

  logic               ov_r, ov_nxt;
  kind_t              okind_r, okind_nxt;
  logic [7:0]         obyte_r, obyte_nxt;
  logic               oupd_r, oupd_nxt;
  logic [7:0]         otlen_r, otlen_nxt;

  logic               in_acc, pass_audio, is_meta, blk_end, meta_wr;
  logic [MPOS_W-1:0]  mpos_inc;
  scan_ctl_t          sctl;
  scan_sts_t          ssts;
  logic [TADDR_W-1:0] title_len;
  logic [MADDR_W-1:0] meta_rd_addr;
  logic [7:0]         meta_rd_data;
  logic               title_wr_en;
  logic [TADDR_W-1:0] title_wr_addr;
  logic [7:0]         title_wr_data, title_rd_data;

  assign in_stall   = (st_r != T_IDLE) || (ov_r && out_stall);
  assign in_acc     = in_valid && !in_stall;
  assign pass_audio = (ivl_r == '0) || (ph_r == PH_AUDIO && acnt_r != '0);
  assign is_meta    = !pass_audio && ph_r == PH_META;
  assign mpos_inc   = mpos_r + 1'b1;
  assign blk_end    = in_acc && !in_action && is_meta && !(mpos_inc < msize_r);
  // only the first META_DEPTH bytes of a block are kept
  assign meta_wr    = in_acc && !in_action && is_meta &&
                      ({1'b0, mpos_r} < (MPOS_W + 1)'(META_DEPTH));

  assign sctl.start = blk_end;
  assign sctl.limit = ({1'b0, msize_r} < (MPOS_W + 1)'(META_DEPTH)) ? msize_r
                                                                    : MPOS_W'(META_DEPTH - 1);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE: begin
        if (in_acc && in_action) st_nxt = T_READ;
        else if (blk_end)        st_nxt = T_SCAN;
      end
      T_READ:  st_nxt = T_IDLE;
      T_SCAN:  if (ssts.done) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  // framing and output register
  always_comb begin
    ivl_nxt    = ivl_r;
    ph_nxt     = ph_r;
    acnt_nxt   = acnt_r;
    msize_nxt  = msize_r;
    mpos_nxt   = mpos_r;
    rd_hit_nxt = rd_hit_r;
    ov_nxt     = ov_r && out_stall;
    okind_nxt  = okind_r;
    obyte_nxt  = obyte_r;
    oupd_nxt   = oupd_r;
    otlen_nxt  = otlen_r;

    if (cfg_wr_en) begin
      ivl_nxt   = cfg_wr_data;
      acnt_nxt  = cfg_wr_data;
      ph_nxt    = PH_AUDIO;
      mpos_nxt  = '0;
      msize_nxt = '0;
    end else if (in_acc) begin
      if (in_action) begin
        rd_hit_nxt = (in_title_index < title_len);
      end else if (pass_audio) begin
        if (ivl_r != '0) acnt_nxt = acnt_r - 1'b1;
        ov_nxt    = 1'b1;
        okind_nxt = KIND_AUDIO;
        obyte_nxt = in_data_byte;
        oupd_nxt  = 1'b0;
        otlen_nxt = title_len;
      end else if (ph_r == PH_META) begin
        mpos_nxt = mpos_inc;
        if (blk_end) begin
          ph_nxt   = PH_AUDIO;
          acnt_nxt = ivl_r;
        end
      end else begin
        // length byte
        if (in_data_byte == 8'h00) begin
          acnt_nxt = ivl_r;
        end else begin
          msize_nxt = MPOS_W'({in_data_byte, BLOCK_SHIFT'(0)});
          mpos_nxt  = '0;
          ph_nxt    = PH_META;
        end
      end
    end

    if (st_r == T_READ) begin
      ov_nxt    = 1'b1;
      okind_nxt = KIND_TITLE;
      obyte_nxt = rd_hit_r ? title_rd_data : 8'h00;
      oupd_nxt  = 1'b0;
      otlen_nxt = title_len;
    end else if (st_r == T_SCAN && ssts.done) begin
      ov_nxt    = 1'b1;
      okind_nxt = KIND_BLOCK;
      obyte_nxt = 8'h00;
      oupd_nxt  = ssts.updated;
      otlen_nxt = title_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= T_IDLE;
      ivl_r   <= '0;
      ph_r    <= PH_AUDIO;
      acnt_r  <= '0;
      msize_r <= '0;
      mpos_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ivl_r   <= ivl_nxt;
      ph_r    <= ph_nxt;
      acnt_r  <= acnt_nxt;
      msize_r <= msize_nxt;
      mpos_r  <= mpos_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_hit_r <= rd_hit_nxt;
    okind_r  <= okind_nxt;
    obyte_r  <= obyte_nxt;
    oupd_r   <= oupd_nxt;
    otlen_r  <= otlen_nxt;
  end

  assign out_valid         = ov_r;
  assign out_kind          = okind_r;
  assign out_out_byte      = obyte_r;
  assign out_title_updated = oupd_r;
  assign out_title_length  = otlen_r;

  icy_ram #(.DEPTH(META_DEPTH), .WIDTH(8)) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr),
    .wr_addr (mpos_r[MADDR_W-1:0]),
    .wr_data (in_data_byte),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_rd_data)
  );

  icy_ram #(.DEPTH(TITLE_DEPTH), .WIDTH(8)) u_title_ram (
    .clk     (clk),
    .wr_en   (title_wr_en),
    .wr_addr (title_wr_addr),
    .wr_data (title_wr_data),
    .rd_addr (in_title_index[TADDR_W-1:0]),
    .rd_data (title_rd_data)
  );

  icy_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (sctl),
    .sts           (ssts),
    .title_len     (title_len),
    .meta_rd_addr  (meta_rd_addr),
    .meta_rd_data  (meta_rd_data),
    .title_wr_en   (title_wr_en),
    .title_wr_addr (title_wr_addr),
    .title_wr_data (title_wr_data)
  );

endmodule

/* hdl/icy_ram.sv */
// ----------------------------------------------------------------------------
// icy_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module icy_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/icy_scan.sv */
// ----------------------------------------------------------------------------
// icy_scan
// Block-end title search: one pass over the metadata store with a byte
// compare unit, then, when a title is found, a copy pass into the title store.
// ----------------------------------------------------------------------------
module icy_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  icy_pkg::scan_ctl_t        ctl,
  output icy_pkg::scan_sts_t        sts,
  output logic [icy_pkg::TADDR_W-1:0] title_len,
  output logic [icy_pkg::MADDR_W-1:0] meta_rd_addr,
  input  logic [7:0]                meta_rd_data,
  output logic                      title_wr_en,
  output logic [icy_pkg::TADDR_W-1:0] title_wr_addr,
  output logic [7:0]                title_wr_data
);
  import icy_pkg::*;

  scan_st_t            st_r, st_nxt;
  logic [MPOS_W-1:0]   addr_r, addr_nxt;
  logic [MPOS_W-1:0]   lim_r, lim_nxt;
  logic                rv_r, rv_nxt;
  logic [MPOS_W-1:0]   rq_r, rq_nxt;
  logic [3:0]          mst_r, mst_nxt;
  logic                key_r, key_nxt;
  logic [MPOS_W-1:0]   p_r, p_nxt;
  logic                prevq_r, prevq_nxt;
  logic                qf_r, qf_nxt;
  logic [MPOS_W-1:0]   qpos_r, qpos_nxt;
  logic                sf_r, sf_nxt;
  logic [MPOS_W-1:0]   spos_r, spos_nxt;
  logic [TADDR_W-1:0]  len_r, len_nxt;
  logic [TADDR_W-1:0]  cnt_r, cnt_nxt;
  logic                wv_r, wv_nxt;
  logic [TADDR_W-1:0]  wa_r, wa_nxt;
  logic [TADDR_W-1:0]  tlen_r, tlen_nxt;
  logic                upd_r, upd_nxt;

  logic                find_end, copy_end, title_ok;
  logic [MPOS_W-1:0]   jsel, diff;
  logic [TADDR_W-1:0]  len_clip;
  logic [MPOS_W-1:0]   copy_addr;

  assign find_end = (rv_r && meta_rd_data == 8'h00) || (!rv_r && addr_r >= lim_r);
  assign copy_end = !wv_r && cnt_r >= len_r;
  assign title_ok = key_r && (sf_r || qf_r);
  assign jsel     = sf_r ? spos_r : qpos_r;
  assign diff     = jsel - p_r;
  assign len_clip = (diff > MPOS_W'(TITLE_DEPTH - 1)) ? TADDR_W'(TITLE_DEPTH - 1)
                                                      : diff[TADDR_W-1:0];
  assign copy_addr = p_r + MPOS_W'(cnt_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      SC_IDLE: if (ctl.start) st_nxt = SC_FIND;
      SC_FIND: if (find_end) st_nxt = title_ok ? SC_COPY : SC_DONE;
      SC_COPY: if (copy_end) st_nxt = SC_DONE;
      SC_DONE: st_nxt = SC_IDLE;
      default: st_nxt = SC_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    meta_rd_addr  = (st_r == SC_COPY) ? copy_addr[MADDR_W-1:0] : addr_r[MADDR_W-1:0];
    title_wr_en   = (st_r == SC_COPY) && wv_r;
    title_wr_addr = wa_r;
    title_wr_data = meta_rd_data;
    sts.done      = (st_r == SC_DONE);
    sts.updated   = upd_r;
    title_len     = tlen_r;
  end

  // datapath
  always_comb begin
    addr_nxt  = addr_r;
    lim_nxt   = lim_r;
    rv_nxt    = 1'b0;
    rq_nxt    = rq_r;
    mst_nxt   = mst_r;
    key_nxt   = key_r;
    p_nxt     = p_r;
    prevq_nxt = prevq_r;
    qf_nxt    = qf_r;
    qpos_nxt  = qpos_r;
    sf_nxt    = sf_r;
    spos_nxt  = spos_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    wv_nxt    = 1'b0;
    wa_nxt    = wa_r;
    tlen_nxt  = tlen_r;
    upd_nxt   = upd_r;
    case (st_r)
      SC_IDLE: begin
        addr_nxt  = '0;
        lim_nxt   = ctl.limit;
        mst_nxt   = '0;
        key_nxt   = 1'b0;
        prevq_nxt = 1'b0;
        qf_nxt    = 1'b0;
        sf_nxt    = 1'b0;
      end
      SC_FIND: begin
        if (addr_r < lim_r) begin
          rv_nxt   = 1'b1;
          rq_nxt   = addr_r;
          addr_nxt = addr_r + 1'b1;
        end
        if (rv_r && meta_rd_data != 8'h00) begin
          if (!key_r) begin
            if (meta_rd_data == key_char(mst_r)) begin
              if (mst_r == 4'(KEY_LEN - 1)) begin
                key_nxt   = 1'b1;
                p_nxt     = rq_r + 1'b1;
                prevq_nxt = 1'b0;
              end else begin
                mst_nxt = mst_r + 1'b1;
              end
            end else begin
              mst_nxt = (meta_rd_data == key_char(4'd0)) ? 4'd1 : 4'd0;
            end
          end else begin
            if (meta_rd_data == CH_QUOTE && !qf_r) begin
              qf_nxt   = 1'b1;
              qpos_nxt = rq_r;
            end
            if (prevq_r && meta_rd_data == CH_SEMI && !sf_r) begin
              sf_nxt   = 1'b1;
              spos_nxt = rq_r - 1'b1;
            end
            prevq_nxt = (meta_rd_data == CH_QUOTE);
          end
        end
        if (find_end) begin
          rv_nxt  = 1'b0;
          len_nxt = len_clip;
          cnt_nxt = '0;
          upd_nxt = title_ok;
        end
      end
      SC_COPY: begin
        if (cnt_r < len_r) begin
          wv_nxt  = 1'b1;
          wa_nxt  = cnt_r;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (copy_end) tlen_nxt = len_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SC_IDLE;
      rv_r   <= 1'b0;
      wv_r   <= 1'b0;
      tlen_r <= '0;
      upd_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rv_r   <= rv_nxt;
      wv_r   <= wv_nxt;
      tlen_r <= tlen_nxt;
      upd_r  <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    lim_r   <= lim_nxt;
    rq_r    <= rq_nxt;
    mst_r   <= mst_nxt;
    key_r   <= key_nxt;
    p_r     <= p_nxt;
    prevq_r <= prevq_nxt;
    qf_r    <= qf_nxt;
    qpos_r  <= qpos_nxt;
    sf_r    <= sf_nxt;
    spos_r  <= spos_nxt;
    len_r   <= len_nxt;
    cnt_r   <= cnt_nxt;
    wa_r    <= wa_nxt;
  end

endmodule

/* hdl/icy_chk.sv */
// ----------------------------------------------------------------------------
// icy_chk
// Port-level checks for the ICY metadata demux, bound to the top level.
// ----------------------------------------------------------------------------
module icy_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_out_byte,
  input logic       out_title_updated,
  input logic [7:0] out_title_length
);
  import icy_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_out_byte))
    else $error("stalled result beat changed");

  a_blk_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BLOCK |-> out_out_byte == 8'h00)
    else $error("block end beat carries a byte");

  a_upd_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BLOCK |-> !out_title_updated)
    else $error("title_updated outside block end");

  a_empty_title: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TITLE && out_title_length == 8'h00
      |-> out_out_byte == 8'h00)
    else $error("character read from empty title");

endmodule

bind icy_metadata_demux icy_chk u_icy_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_out_byte      (out_out_byte),
  .out_title_updated (out_title_updated),
  .out_title_length  (out_title_length)
);
